// ===== design/gtfd_pkg.sv =====
`timescale 1ns / 1ps

package gtfd_pkg;

   // Texture format codes held in the format register
   localparam logic [3:0] FMT_I4     = 4'd0;
   localparam logic [3:0] FMT_I8     = 4'd1;
   localparam logic [3:0] FMT_IA4    = 4'd2;
   localparam logic [3:0] FMT_IA8    = 4'd3;
   localparam logic [3:0] FMT_RGB565 = 4'd4;
   localparam logic [3:0] FMT_RGB5A3 = 4'd5;
   localparam logic [3:0] FMT_RGBA8  = 4'd6;
   localparam logic [3:0] FMT_CMPR   = 4'd14;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified item: a four-entry palette, 2-bit selects for up to
   // sixteen pixels (pixel 0 in bits 31:30), and the slot of the last pixel
   typedef struct packed {
      logic [3:0][31:0] palette;
      logic [31:0]      selects;
      logic [3:0]       last_slot;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

// ===== design/gtfd_front.sv =====
`timescale 1ns / 1ps

module gtfd_front (
   input  logic [3:0]         texel_format,
   input  logic [63:0]        texel_word,
   output logic               supported,
   output gtfd_pkg::entry_type entry
);

   // Expand an RGB565 color by plain left shift
   function automatic logic [31:0] expand565(input logic [15:0] v, input logic [7:0] alpha);
      expand565 = {alpha, v[15:11], 3'b000, v[10:5], 2'b00, v[4:0], 3'b000};
   endfunction

   // Divide a value below 256 by three with a reciprocal multiply
   function automatic logic [7:0] div3(input logic [7:0] x);
      logic [18:0] prod;
      prod = {11'd0, x} * 19'd683;
      div3 = prod[18:11];
   endfunction

   logic [7:0]  byte_val;
   logic [15:0] half_val;
   logic [15:0] c0;
   logic [15:0] c1;
   logic        c0_gt;
   logic [7:0]  r0, g0, b0, r1, g1, b1;
   logic [7:0]  r2_sum, g2_sum, b2_sum, r3_sum, g3_sum, b3_sum;
   logic [7:0]  r2, g2, b2, r3, g3, b3;
   logic [15:0] col2;
   logic [15:0] col3;

   assign byte_val = texel_word[7:0];
   assign half_val = texel_word[15:0];
   assign c0       = texel_word[63:48];
   assign c1       = texel_word[47:32];
   assign c0_gt    = c0 > c1;

   assign r0 = {3'd0, c0[15:11]};
   assign g0 = {2'd0, c0[10:5]};
   assign b0 = {3'd0, c0[4:0]};
   assign r1 = {3'd0, c1[15:11]};
   assign g1 = {2'd0, c1[10:5]};
   assign b1 = {3'd0, c1[4:0]};

   // Weighted sums for the two interpolated colors
   always_comb begin
      if (c0_gt) begin
         r2_sum = (r0 << 1) + r1;
         g2_sum = (g0 << 1) + g1;
         b2_sum = (b0 << 1) + b1;
         r3_sum = r0 + (r1 << 1);
         g3_sum = g0 + (g1 << 1);
         b3_sum = b0 + (b1 << 1);
         r2 = div3(r2_sum);
         g2 = div3(g2_sum);
         b2 = div3(b2_sum);
         r3 = div3(r3_sum);
         g3 = div3(g3_sum);
         b3 = div3(b3_sum);
      end else begin
         r2_sum = r0 + r1;
         g2_sum = g0 + g1;
         b2_sum = b0 + b1;
         r3_sum = r1;
         g3_sum = g1;
         b3_sum = b1;
         r2 = r2_sum >> 1;
         g2 = g2_sum >> 1;
         b2 = b2_sum >> 1;
         r3 = r3_sum;
         g3 = g3_sum;
         b3 = b3_sum;
      end
   end

   assign col2 = {r2[4:0], g2[5:0], b2[4:0]};
   assign col3 = {r3[4:0], g3[5:0], b3[4:0]};

   // Classify the item and build its palette
   always_comb begin
      supported       = 1'b1;
      entry.palette   = '0;
      entry.selects   = '0;
      entry.last_slot = 4'd0;
      case (texel_format)
         gtfd_pkg::FMT_I4: begin
            entry.palette[0] = {8'hFF, {3{byte_val[7:4], 4'h0}}};
            entry.palette[1] = {8'hFF, {3{byte_val[3:0], 4'h0}}};
            entry.selects    = 32'h1000_0000;
            entry.last_slot  = 4'd1;
         end
         gtfd_pkg::FMT_I8: begin
            entry.palette[0] = {8'hFF, {3{byte_val}}};
         end
         gtfd_pkg::FMT_IA4: begin
            entry.palette[0] = {byte_val[7:4], 4'h0, {3{byte_val[3:0], 4'h0}}};
         end
         gtfd_pkg::FMT_IA8: begin
            entry.palette[0] = {half_val[7:0], {3{half_val[15:8]}}};
         end
         gtfd_pkg::FMT_RGB565: begin
            entry.palette[0] = expand565(half_val, 8'hFF);
         end
         gtfd_pkg::FMT_RGB5A3: begin
            if (half_val[15]) begin
               entry.palette[0] = {8'hFF, half_val[14:10], 3'b000,
                                   half_val[9:5], 3'b000, half_val[4:0], 3'b000};
            end else begin
               entry.palette[0] = {half_val[14:12], 5'b00000, half_val[11:8], 4'h0,
                                   half_val[7:4], 4'h0, half_val[3:0], 4'h0};
            end
         end
         gtfd_pkg::FMT_RGBA8: begin
            entry.palette[0] = texel_word[31:0];
         end
         gtfd_pkg::FMT_CMPR: begin
            entry.palette[0] = expand565(c0, 8'hFF);
            entry.palette[1] = expand565(c1, 8'hFF);
            entry.palette[2] = expand565(col2, 8'hFF);
            entry.palette[3] = expand565(col3, c0_gt ? 8'hFF : 8'h00);
            entry.selects    = texel_word[31:0];
            entry.last_slot  = 4'd15;
         end
         default: begin
            supported = 1'b0;
         end
      endcase
   end

endmodule

// ===== design/gtfd_queue.sv =====
`timescale 1ns / 1ps

module gtfd_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  gtfd_pkg::entry_type            push_entry,
   input  logic                           pop,
   output gtfd_pkg::entry_type            head_entry,
   output gtfd_pkg::queue_status_type     status
);

   gtfd_pkg::entry_type slots_ff [gtfd_pkg::QUEUE_DEPTH];

   logic [gtfd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gtfd_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gtfd_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == gtfd_pkg::QUEUE_PTR_W'(gtfd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == gtfd_pkg::QUEUE_PTR_W'(gtfd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry       = slots_ff[rd_ptr_ff];
   assign status.not_empty = count_ff != '0;
   assign status.full      = count_ff == gtfd_pkg::QUEUE_CNT_W'(gtfd_pkg::QUEUE_DEPTH);

endmodule

// ===== design/gtfd_back.sv =====
`timescale 1ns / 1ps

module gtfd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  gtfd_pkg::entry_type        head_entry,
   input  gtfd_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_strobe,
   output logic [31:0]                rsp_argb_pixel,
   output logic [3:0]                 rsp_pixel_slot,
   output logic                       rsp_last_pixel
);

   logic [3:0]  slot_ff, slot_in;
   logic        strobe_ff;
   logic [31:0] pixel_ff;
   logic [3:0]  pixel_slot_ff;
   logic        last_ff;
   logic [31:0] shifted;
   logic [1:0]  sel;
   logic        is_last;

   // Pick this beat's palette entry
   assign shifted = head_entry.selects << {slot_ff, 1'b0};
   assign sel     = shifted[31:30];
   assign is_last = slot_ff == head_entry.last_slot;
   assign pop     = status.not_empty && is_last;

   always_comb begin
      slot_in = slot_ff;
      if (status.not_empty) begin
         slot_in = is_last ? 4'd0 : slot_ff + 4'd1;
      end
   end

   // Hold slot counter and strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= 4'd0;
         strobe_ff <= 1'b0;
      end else begin
         slot_ff   <= slot_in;
         strobe_ff <= status.not_empty;
      end
   end

   // Register the outgoing beat
   always_ff @(posedge clock) begin
      pixel_ff      <= head_entry.palette[sel];
      pixel_slot_ff <= slot_ff;
      last_ff       <= is_last;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_argb_pixel = pixel_ff;
   assign rsp_pixel_slot = pixel_slot_ff;
   assign rsp_last_pixel = last_ff;

endmodule

// ===== design/gx_texel_format_decoder_core.sv =====
`timescale 1ns / 1ps

// Texel format decoder: one texel word in on start (when busy is low), ARGB8888
// pixels out one per cycle on rsp_strobe. The receiver cannot stall: each
// pixel is on the rsp_ ports for exactly one cycle. I8, IA4, IA8, RGB565,
// RGB5A3 and RGBA8 yield one pixel per item, I4 two and CMPR sixteen; the
// output port, which sends one pixel per cycle, sets the item rate. A new
// item is accepted every cycle while the two-entry queue between decode and
// output has room; busy is high while it is full and not draining. With the
// queue empty, an accepted item is written into the queue, then its first
// pixel is registered in the output stage. Items in an unsupported format
// are taken and produce no pixels. Write the format register only while no
// pixels are pending.

module gx_texel_format_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_texel_word,
   output logic        rsp_strobe,
   output logic [31:0] rsp_argb_pixel,
   output logic [3:0]  rsp_pixel_slot,
   output logic        rsp_last_pixel
);

   logic [3:0]                 texel_format_ff;
   logic                       supported;
   gtfd_pkg::entry_type        front_entry;
   gtfd_pkg::entry_type        head_entry;
   gtfd_pkg::queue_status_type status;
   logic                       pop;
   logic                       push;

   // Hold the format register
   always_ff @(posedge clock) begin
      if (reset) begin
         texel_format_ff <= gtfd_pkg::FMT_I4;
      end else if (csr_write_enable) begin
         texel_format_ff <= csr_write_data;
      end
   end

   assign busy = status.full && !pop;
   assign push = start && !busy && supported;

   gtfd_front u_front (
      .texel_format (texel_format_ff),
      .texel_word   (req_texel_word),
      .supported    (supported),
      .entry        (front_entry)
   );

   gtfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (status)
   );

   gtfd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .status         (status),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_argb_pixel (rsp_argb_pixel),
      .rsp_pixel_slot (rsp_pixel_slot),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

// ===== tb/gtfd_pixel_checker.sv =====
`timescale 1ns / 1ps

module gtfd_pixel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   input  logic        start,
   input  logic        busy,
   input  logic [63:0] req_texel_word,
   input  logic        rsp_strobe,
   input  logic [31:0] rsp_argb_pixel,
   input  logic [3:0]  rsp_pixel_slot,
   input  logic        rsp_last_pixel,
   output int          mismatch_count,
   output int          pending_count,
   output int          pixel_count
);

   typedef struct packed {
      logic [31:0] argb;
      logic [3:0]  slot;
      logic        last;
   } pixel_beat_type;

   pixel_beat_type pending_pixels[$];
   pixel_beat_type oldest;
   logic [3:0]     shadow_format;

   // Widen an RGB565 color by plain shifts, no bit replication
   function automatic logic [31:0] expand565(input logic [15:0] c, input logic [7:0] alpha);
      return {alpha, c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
   endfunction

   // Weighted per-channel average of two RGB565 colors, quotient truncated
   function automatic logic [15:0] mix565(input int unsigned wa, input int unsigned wb,
                                          input logic [15:0] ca, input logic [15:0] cb);
      int unsigned total;
      int unsigned r;
      int unsigned g;
      int unsigned b;
      total = wa + wb;
      r = (wa * ca[15:11] + wb * cb[15:11]) / total;
      g = (wa * ca[10:5] + wb * cb[10:5]) / total;
      b = (wa * ca[4:0] + wb * cb[4:0]) / total;
      return {r[4:0], g[5:0], b[4:0]};
   endfunction

   // Decode one texel word under the given format and queue its pixels
   task automatic predict_pixels(input logic [3:0] fmt, input logic [63:0] w);
      logic [31:0]    pix[16];
      logic [31:0]    pal[4];
      logic [15:0]    c0;
      logic [15:0]    c1;
      logic [1:0]     sel;
      pixel_beat_type beat;
      int             n;
      n = 1;
      case (fmt)
         gtfd_pkg::FMT_I4: begin
            pix[0] = {8'hFF, {3{w[7:4], 4'h0}}};
            pix[1] = {8'hFF, {3{w[3:0], 4'h0}}};
            n = 2;
         end
         gtfd_pkg::FMT_I8:     pix[0] = {8'hFF, {3{w[7:0]}}};
         gtfd_pkg::FMT_IA4:    pix[0] = {w[7:4], 4'h0, {3{w[3:0], 4'h0}}};
         gtfd_pkg::FMT_IA8:    pix[0] = {w[7:0], {3{w[15:8]}}};
         gtfd_pkg::FMT_RGB565: pix[0] = expand565(w[15:0], 8'hFF);
         gtfd_pkg::FMT_RGB5A3: begin
            // bit 15 picks opaque 555 or translucent 3444
            if (w[15]) begin
               pix[0] = {8'hFF, w[14:10], 3'b000, w[9:5], 3'b000, w[4:0], 3'b000};
            end else begin
               pix[0] = {w[14:12], 5'b00000, w[11:8], 4'h0, w[7:4], 4'h0, w[3:0], 4'h0};
            end
         end
         gtfd_pkg::FMT_RGBA8: pix[0] = w[31:0];
         gtfd_pkg::FMT_CMPR: begin
            c0 = w[63:48];
            c1 = w[47:32];
            pal[0] = expand565(c0, 8'hFF);
            pal[1] = expand565(c1, 8'hFF);
            // four-color block when c0 > c1, else three colors plus transparent
            if (c0 > c1) begin
               pal[2] = expand565(mix565(2, 1, c0, c1), 8'hFF);
               pal[3] = expand565(mix565(1, 2, c0, c1), 8'hFF);
            end else begin
               pal[2] = expand565(mix565(1, 1, c0, c1), 8'hFF);
               pal[3] = expand565(c1, 8'h00);
            end
            for (int k = 0; k < 16; k++) begin
               sel = w[31 - 2 * k -: 2];
               pix[k] = pal[sel];
            end
            n = 16;
         end
         default: n = 0;
      endcase
      for (int k = 0; k < n; k++) begin
         beat.argb = pix[k];
         beat.slot = 4'(k);
         beat.last = (k == n - 1);
         pending_pixels.push_back(beat);
      end
   endtask

   // Compare pixel beats, predict accepted items, track format writes
   always @(posedge clock) begin
      if (reset) begin
         shadow_format = gtfd_pkg::FMT_I4;
         pending_pixels.delete();
      end else begin
         if (rsp_strobe) begin
            pixel_count++;
            if (pending_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected pixel argb=%08h slot=%0d last=%0d", $realtime,
                           rsp_argb_pixel, rsp_pixel_slot, rsp_last_pixel);
            end else begin
               oldest = pending_pixels.pop_front();
               if (rsp_argb_pixel !== oldest.argb || rsp_pixel_slot !== oldest.slot ||
                   rsp_last_pixel !== oldest.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: pixel mismatch exp argb=%08h slot=%0d last=%0d",
                              $realtime, oldest.argb, oldest.slot, oldest.last);
                     $display("%0t:                got argb=%08h slot=%0d last=%0d",
                              $realtime, rsp_argb_pixel, rsp_pixel_slot, rsp_last_pixel);
                  end
               end
            end
         end
         if (start && !busy)
            predict_pixels(shadow_format, req_texel_word);
         if (csr_write_enable)
            shadow_format = csr_write_data;
      end
      pending_count = pending_pixels.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int ITEM_TARGET = 350;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [3:0]  csr_write_data = '0;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_texel_word = '0;
   logic        rsp_strobe;
   logic [31:0] rsp_argb_pixel;
   logic [3:0]  rsp_pixel_slot;
   logic        rsp_last_pixel;

   int mismatch_count;
   int pending_count;
   int pixel_count;
   int cycle_count = 0;
   int words_sent = 0;
   int format_writes = 0;
   int words_per_format[16];

   logic [3:0] supported_fmts[8] = '{gtfd_pkg::FMT_I4, gtfd_pkg::FMT_I8, gtfd_pkg::FMT_IA4,
                                     gtfd_pkg::FMT_IA8, gtfd_pkg::FMT_RGB565,
                                     gtfd_pkg::FMT_RGB5A3, gtfd_pkg::FMT_RGBA8,
                                     gtfd_pkg::FMT_CMPR};
   logic [3:0] unsupported_fmts[$];
   logic [3:0] cur_format = gtfd_pkg::FMT_I4;

   gx_texel_format_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .start            (start),
      .busy             (busy),
      .req_texel_word   (req_texel_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_argb_pixel   (rsp_argb_pixel),
      .rsp_pixel_slot   (rsp_pixel_slot),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   gtfd_pixel_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .start            (start),
      .busy             (busy),
      .req_texel_word   (req_texel_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_argb_pixel   (rsp_argb_pixel),
      .rsp_pixel_slot   (rsp_pixel_slot),
      .rsp_last_pixel   (rsp_last_pixel),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .pixel_count      (pixel_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels still pending", cycle_count,
                  pending_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Random word; for CMPR steer the c0/c1 order so both palette modes show up
   function automatic logic [63:0] random_word(input logic [3:0] fmt);
      logic [63:0] w;
      logic [15:0] hold;
      int          r;
      w = {$urandom, $urandom};
      if (fmt == gtfd_pkg::FMT_CMPR) begin
         r = $urandom_range(0, 7);
         if (r == 0) begin
            w[47:32] = w[63:48];
         end else if ((r < 4) != (w[63:48] > w[47:32])) begin
            hold = w[63:48];
            w[63:48] = w[47:32];
            w[47:32] = hold;
         end
         if ($urandom_range(0, 5) == 0)
            w[31:0] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'hAAAA_AAAA;
      end
      return w;
   endfunction

   // Drive one beat and hold it until the block takes it
   task automatic send_word(input logic [63:0] w, input bit with_gaps);
      int g;
      req_texel_word <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      words_sent++;
      words_per_format[cur_format]++;
      g = with_gaps ? gap_len() : 0;
      if (g > 0) begin
         start <= 1'b0;
         req_texel_word <= {$urandom, $urandom};
         repeat (g) @(posedge clock);
      end
   endtask

   // Drain all pixels, let the pipeline settle, then write the format
   task automatic set_format(input logic [3:0] f);
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= f;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data <= 4'($urandom);
      cur_format = f;
      format_writes++;
   endtask

   initial begin
      int         phase_len;
      int         unsup_idx;
      int         phase;
      bit         with_gaps;
      logic [3:0] f;

      for (int i = 0; i < 16; i++) begin
         words_per_format[i] = 0;
         f = 4'(i);
         case (f)
            gtfd_pkg::FMT_I4, gtfd_pkg::FMT_I8, gtfd_pkg::FMT_IA4, gtfd_pkg::FMT_IA8,
            gtfd_pkg::FMT_RGB565, gtfd_pkg::FMT_RGB5A3, gtfd_pkg::FMT_RGBA8,
            gtfd_pkg::FMT_CMPR: ;
            default: unsupported_fmts.push_back(f);
         endcase
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes per format, both RGB5A3 modes, CMPR palette cases
      foreach (supported_fmts[i]) begin
         set_format(supported_fmts[i]);
         send_word(64'h0, 1'b1);
         send_word('1, 1'b1);
         if (supported_fmts[i] == gtfd_pkg::FMT_RGB5A3) begin
            send_word(64'h7FFF, 1'b1);
            send_word(64'h8000, 1'b1);
         end
         if (supported_fmts[i] == gtfd_pkg::FMT_CMPR) begin
            send_word(64'hFFFF_0000_1B1B_1B1B, 1'b0);
            send_word(64'h0000_FFFF_E4E4_E4E4, 1'b0);
            send_word(64'hF800_07E0_1B1B_1B1B, 1'b1);
         end
      end
      set_format(unsupported_fmts[unsupported_fmts.size() - 1]);
      send_word('1, 1'b1);

      // Random phases; every third one walks the unsupported codes
      unsup_idx = 0;
      phase = 0;
      while (words_sent < ITEM_TARGET) begin
         if (phase % 3 == 2 && unsup_idx < unsupported_fmts.size()) begin
            f = unsupported_fmts[unsup_idx];
            unsup_idx++;
            phase_len = $urandom_range(2, 6);
         end else begin
            f = supported_fmts[$urandom_range(0, 9) > 7 ? 7 : $urandom_range(0, 7)];
            phase_len = $urandom_range(5, 30);
         end
         with_gaps = ($urandom_range(0, 3) != 0);
         set_format(f);
         repeat (phase_len) send_word(random_word(f), with_gaps);
         phase++;
      end

      // Drain and let the pipeline settle
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d texel words across %0d format writes; %0d pixels checked.",
               words_sent, format_writes, pixel_count);
      $display("Words per format: I4 %0d I8 %0d IA4 %0d IA8 %0d",
               words_per_format[gtfd_pkg::FMT_I4], words_per_format[gtfd_pkg::FMT_I8],
               words_per_format[gtfd_pkg::FMT_IA4], words_per_format[gtfd_pkg::FMT_IA8]);
      $display("Words per format: RGB565 %0d RGB5A3 %0d RGBA8 %0d CMPR %0d",
               words_per_format[gtfd_pkg::FMT_RGB565],
               words_per_format[gtfd_pkg::FMT_RGB5A3],
               words_per_format[gtfd_pkg::FMT_RGBA8],
               words_per_format[gtfd_pkg::FMT_CMPR]);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d pixels missing", mismatch_count, pending_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
